// ===== rtl/core/tldn_pkg.sv =====
// Shared types and constants for the day/night traffic light controller.
// Used by every module under rtl/core; no dependencies of its own.
`timescale 1ns / 1ps

package tldn_pkg;

    // Field widths
    localparam int unsigned PhaseW  = 4;
    localparam int unsigned CountW  = 8;
    localparam int unsigned LampW   = 5;
    localparam int unsigned LevelW  = 8;
    localparam int unsigned ThreshW = 9;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 9;
    localparam int unsigned OutW    = 8;

    // Saturation limits
    localparam logic [PhaseW-1:0] PhaseMax = 4'd15;
    localparam logic [CountW-1:0] CountMax = 8'd255;

    // Lamp bit positions inside the lamp pattern
    localparam int unsigned LampGreen  = 0;
    localparam int unsigned LampYellow = 1;
    localparam int unsigned LampRed    = 2;
    localparam int unsigned LampWGreen = 3;
    localparam int unsigned LampWRed   = 4;

    // Lamp masks
    localparam logic [LampW-1:0] MaskGreen  = 5'b00001;
    localparam logic [LampW-1:0] MaskYellow = 5'b00010;
    localparam logic [LampW-1:0] MaskRed    = 5'b00100;
    localparam logic [LampW-1:0] MaskWGreen = 5'b01000;
    localparam logic [LampW-1:0] MaskWRed   = 5'b10000;

    // Request kinds
    localparam logic ModeTick   = 1'b0;
    localparam logic ModeButton = 1'b1;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_LIGHT_THRESHOLD = 3'd0,
        CFG_NIGHT_TICKS     = 3'd1,
        CFG_DAY_TICKS       = 3'd2,
        CFG_GREEN_END       = 3'd3,
        CFG_YELLOW_END      = 3'd4,
        CFG_CYCLE_LENGTH    = 3'd5
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [ThreshW-1:0] RstLightThreshold = 9'd100;
    localparam logic [CountW-1:0]  RstNightTicks     = 8'd10;
    localparam logic [CountW-1:0]  RstDayTicks       = 8'd10;
    localparam logic [PhaseW-1:0]  RstGreenEnd       = 4'd5;
    localparam logic [PhaseW-1:0]  RstYellowEnd      = 4'd7;
    localparam logic [PhaseW-1:0]  RstCycleLength    = 4'd12;

    // Reset value of the bright counter (day mode active)
    localparam logic [CountW-1:0]  RstBrightCount    = 8'd10;

    typedef struct packed {
        logic [ThreshW-1:0] light_threshold;
        logic [CountW-1:0]  night_ticks;
        logic [CountW-1:0]  day_ticks;
        logic [PhaseW-1:0]  green_end;
        logic [PhaseW-1:0]  yellow_end;
        logic [PhaseW-1:0]  cycle_length;
    } cfg_t;

    typedef struct packed {
        logic [PhaseW-1:0] phase_time;
        logic [CountW-1:0] dark_count;
        logic [CountW-1:0] bright_count;
        logic              night_latch;
        logic [LampW-1:0]  lamp_pattern;
    } state_t;

endpackage

// ===== rtl/core/tldn_cfg_regs.sv =====
// Configuration register file for the traffic light controller.
// Depends on tldn_pkg for the register indexes, widths and reset values.
`timescale 1ns / 1ps

module tldn_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tldn_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tldn_pkg::CfgDatW-1:0]   cfg_wdata,
    output tldn_pkg::cfg_t                 cfg
);

    tldn_pkg::cfg_t cfg_reg;
    tldn_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (tldn_pkg::cfg_idx_t'(cfg_index))
                tldn_pkg::CFG_LIGHT_THRESHOLD: cfg_next.light_threshold = cfg_wdata;
                tldn_pkg::CFG_NIGHT_TICKS:     cfg_next.night_ticks  = cfg_wdata[7:0];
                tldn_pkg::CFG_DAY_TICKS:       cfg_next.day_ticks    = cfg_wdata[7:0];
                tldn_pkg::CFG_GREEN_END:       cfg_next.green_end    = cfg_wdata[3:0];
                tldn_pkg::CFG_YELLOW_END:      cfg_next.yellow_end   = cfg_wdata[3:0];
                tldn_pkg::CFG_CYCLE_LENGTH:    cfg_next.cycle_length = cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.light_threshold <= tldn_pkg::RstLightThreshold;
            cfg_reg.night_ticks     <= tldn_pkg::RstNightTicks;
            cfg_reg.day_ticks       <= tldn_pkg::RstDayTicks;
            cfg_reg.green_end       <= tldn_pkg::RstGreenEnd;
            cfg_reg.yellow_end      <= tldn_pkg::RstYellowEnd;
            cfg_reg.cycle_length    <= tldn_pkg::RstCycleLength;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/tldn_step.sv =====
// Next-state logic for one request: tick or button update, then day-mode lamps.
// Purely combinational; depends on tldn_pkg for the config and state structs.
`timescale 1ns / 1ps

module tldn_step (
    input  tldn_pkg::cfg_t                cfg,
    input  tldn_pkg::state_t              cur,
    input  logic                          mode,
    input  logic [tldn_pkg::LevelW-1:0]   light_level,
    output tldn_pkg::state_t              nxt
);

    logic day_now;
    logic day_after;
    logic is_dark;

    always_comb begin
        nxt     = cur;
        is_dark = ({1'b0, light_level} < cfg.light_threshold);
        day_now = (cur.bright_count >= cfg.day_ticks);

        if (mode == tldn_pkg::ModeTick) begin
            // Phase time and light counters, both saturating
            if (cur.phase_time != tldn_pkg::PhaseMax) begin
                nxt.phase_time = cur.phase_time + 4'd1;
            end
            if (is_dark) begin
                if (cur.dark_count != tldn_pkg::CountMax) begin
                    nxt.dark_count = cur.dark_count + 8'd1;
                end
            end else begin
                if (cur.bright_count != tldn_pkg::CountMax) begin
                    nxt.bright_count = cur.bright_count + 8'd1;
                end
                nxt.dark_count = '0;
            end
            // Night blink: only yellow survives and it toggles
            if ((nxt.bright_count < cfg.day_ticks) && cur.night_latch) begin
                nxt.lamp_pattern = (cur.lamp_pattern & tldn_pkg::MaskYellow)
                                   ^ tldn_pkg::MaskYellow;
                nxt.phase_time   = '0;
            end
            // Enough dark ticks: enter night mode
            if (nxt.dark_count >= cfg.night_ticks) begin
                nxt.lamp_pattern = nxt.lamp_pattern & tldn_pkg::MaskYellow;
                nxt.phase_time   = '0;
                nxt.bright_count = '0;
                nxt.night_latch  = 1'b1;
            end
        end else if (day_now && (cur.phase_time < cfg.green_end)) begin
            // Button press cuts green short
            nxt.phase_time = cfg.green_end - 4'd1;
        end

        // Day-mode lamp sequence
        day_after = (nxt.bright_count >= cfg.day_ticks);
        if (day_after) begin
            nxt.night_latch = 1'b0;
            if (nxt.phase_time >= cfg.cycle_length) begin
                nxt.phase_time = '0;
            end
            if (nxt.phase_time < cfg.green_end) begin
                nxt.lamp_pattern = tldn_pkg::MaskGreen | tldn_pkg::MaskWRed;
            end else if (nxt.phase_time < cfg.yellow_end) begin
                nxt.lamp_pattern = (nxt.lamp_pattern & ~tldn_pkg::MaskGreen)
                                   | tldn_pkg::MaskYellow;
            end else if (nxt.phase_time < cfg.cycle_length) begin
                nxt.lamp_pattern = (nxt.lamp_pattern
                                    & ~(tldn_pkg::MaskYellow | tldn_pkg::MaskWRed))
                                   | tldn_pkg::MaskRed | tldn_pkg::MaskWGreen;
            end
        end
    end

endmodule

// ===== rtl/core/traffic_light_day_night_controller_core.sv =====
// Top level of the day/night traffic light controller: input register,
// controller state, result register. Uses tldn_pkg, tldn_cfg_regs, tldn_step.
//
//  Channel   Direction  Ports                          Contents
//  input     in         s_tvalid s_tready s_tuser      tuser: mode; tdata: light_level
//                       s_tdata
//  result    out        m_tvalid m_tready m_tdata      tdata: lamps and night_active
//  config    in         cfg_we cfg_index cfg_wdata     one register write per cycle
//
// One request per cycle sustained while m_tready holds; the result passes through the
// input register, then the state update into the result register.
// The state update is a single combinational pass from the input register.
// Reset (aresetn low, synchronous) empties both registers and restores the
// controller state and configuration to their defaults.
// A stalled result holds its register; a new request still enters an empty input
// register and waits there until the result slot frees.
`timescale 1ns / 1ps

module traffic_light_day_night_controller_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input request
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] light_level
    input  logic                          s_tuser,   // [0] mode
    // result
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] car_green [1] car_yellow [2] car_red [3] walk_green [4] walk_red
    // [5] night_active [7:6] zero
    output logic [tldn_pkg::OutW-1:0]     m_tdata,
    // configuration
    input  logic                          cfg_we,
    input  logic [tldn_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tldn_pkg::CfgDatW-1:0]  cfg_wdata
);

    tldn_pkg::cfg_t   cfg;
    tldn_pkg::state_t state_reg;
    tldn_pkg::state_t state_next;

    logic                        in_valid_reg;
    logic                        in_mode_reg;
    logic [tldn_pkg::LevelW-1:0] in_level_reg;
    logic                        out_valid_reg;
    logic [tldn_pkg::OutW-1:0]   out_data_reg;
    logic [tldn_pkg::OutW-1:0]   out_data_next;
    logic                        advance;
    logic                        s_accept;

    tldn_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tldn_step u_step (
        .cfg         (cfg),
        .cur         (state_reg),
        .mode        (in_mode_reg),
        .light_level (in_level_reg),
        .nxt         (state_next)
    );

    // Handshake: the held request moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg  <= s_tuser;
            in_level_reg <= s_tdata;
        end
    end

    // Controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase_time   <= '0;
            state_reg.dark_count   <= '0;
            state_reg.bright_count <= tldn_pkg::RstBrightCount;
            state_reg.night_latch  <= 1'b0;
            state_reg.lamp_pattern <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result packing
    assign out_data_next = {2'b00, state_next.night_latch, state_next.lamp_pattern};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // At night only the yellow lamp may be lit
    a_night_yellow_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[tldn_pkg::LampW])
            |-> ((m_tdata[tldn_pkg::LampW-1:0] & ~tldn_pkg::MaskYellow) == '0))
        else $error("lamp other than yellow lit in night mode");

    // Entering night clears phase time and the bright count
    a_night_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.night_latch)
            |-> (state_reg.phase_time == '0 && state_reg.bright_count == '0))
        else $error("night entry left phase or bright count set");

    // State only moves when a request is applied
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("controller state changed without a request");

endmodule
